/* sv/tlrb_pkg.sv */
`default_nettype none

package tlrb_pkg;

   localparam int unsigned LOG_DEPTH     = 65536;
   localparam int unsigned HISTORY_CHUNK = 8192;
   localparam int unsigned ADDR_W        = $clog2(LOG_DEPTH);

   localparam int unsigned CAP_W   = 7;
   localparam int unsigned TOTAL_W = 32;
   localparam int unsigned BYTE_W  = 8;
   localparam logic [CAP_W-1:0] MAX_CAP = CAP_W'(65);

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   typedef struct packed {
      logic wr;
      logic clr;
      logic load;
      logic start;
      logic zero;
      logic clamp;
      logic count;
      logic setup;
      logic stream;
      logic push_empty;
   } ctl_cmd_type;

   typedef struct packed {
      logic zero_cap;
      logic count_zero;
      logic drained;
      logic out_free;
   } ctl_stat_type;

endpackage

`default_nettype wire

/* sv/tlrb_ram.sv */
`default_nettype none

module tlrb_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/tlrb_ctrl.sv */
`default_nettype none

module tlrb_ctrl
   import tlrb_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [1:0]   command,
   input  ctl_stat_type      stat,
   output ctl_cmd_type       cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_START  = 3'd1;
   localparam logic [2:0] S_CLAMP  = 3'd2;
   localparam logic [2:0] S_COUNT  = 3'd3;
   localparam logic [2:0] S_SETUP  = 3'd4;
   localparam logic [2:0] S_STREAM = 3'd5;
   localparam logic [2:0] S_EMPTY  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.wr  = accept && (command == CMD_WRITE);
            cmd.clr = accept && (command == CMD_CLEAR);
            if (accept && (command == CMD_READ)) begin
               cmd.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            if (stat.zero_cap) begin
               cmd.zero = 1'b1;
               state_in = S_EMPTY;
            end else begin
               cmd.start = 1'b1;
               state_in  = S_CLAMP;
            end
         end
         S_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = S_COUNT;
         end
         S_COUNT: begin
            cmd.count = 1'b1;
            state_in  = S_SETUP;
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = stat.count_zero ? S_EMPTY : S_STREAM;
         end
         S_STREAM: begin
            cmd.stream = 1'b1;
            if (stat.drained) begin
               state_in = S_IDLE;
            end
         end
         S_EMPTY: begin
            cmd.push_empty = 1'b1;
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* sv/tlrb_dpath.sv */
`default_nettype none

module tlrb_dpath
   import tlrb_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  ctl_cmd_type             cmd,
   output ctl_stat_type            stat,
   input  wire logic [BYTE_W-1:0]  data_byte,
   input  wire logic [TOTAL_W-1:0] since_offset,
   input  wire logic [CAP_W-1:0]   dest_capacity,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [BYTE_W-1:0]       read_byte,
   output logic                    byte_valid,
   output logic                    last,
   output logic [TOTAL_W-1:0]      next_offset,
   output logic                    overrun,
   output logic [CAP_W-1:0]        bytes_read
);

   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [ADDR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [TOTAL_W-1:0] since_ff;
   logic [CAP_W-1:0]   cap_ff;
   logic [TOTAL_W-1:0] start_ff;
   logic               ovr_ff;
   logic [CAP_W-1:0]   count_ff;
   logic [TOTAL_W-1:0] next_ff;
   logic [ADDR_W-1:0]  rd_addr_ff;
   logic [CAP_W-1:0]   remain_ff;
   logic               dv_ff;
   logic               dv_last_ff;
   logic               out_valid_ff;
   logic [BYTE_W-1:0]  out_byte_ff;
   logic               out_bv_ff;
   logic               out_last_ff;
   logic [TOTAL_W-1:0] out_next_ff;
   logic               out_ovr_ff;
   logic [CAP_W-1:0]   out_count_ff;

   logic [CAP_W-1:0]   room;
   logic [TOTAL_W-1:0] chunk;
   logic [TOTAL_W-1:0] start_calc;
   logic               ovr_calc;
   logic [TOTAL_W-1:0] diff;
   logic [BYTE_W-1:0]  ram_data;
   logic               rd_en;
   logic               dv_move;
   logic               out_free;
   logic               empty_load;
   logic [ADDR_W-1:0]  rd_addr_next;

   tlrb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (LOG_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr),
      .wr_addr (wr_ptr_ff),
      .wr_data (data_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_data)
   );

   assign room  = cap_ff - CAP_W'(1);
   assign chunk = (TOTAL_W'(HISTORY_CHUNK) > TOTAL_W'(room)) ?
                  TOTAL_W'(room) : TOTAL_W'(HISTORY_CHUNK);

   always_comb begin
      start_calc = since_ff;
      ovr_calc   = 1'b0;
      if (since_ff == '0) begin
         start_calc = (total_ff > chunk) ? (total_ff - chunk) : '0;
      end else if ({1'b0, total_ff} >
                   ({1'b0, since_ff} + (TOTAL_W + 1)'(LOG_DEPTH))) begin
         start_calc = total_ff - TOTAL_W'(LOG_DEPTH);
         ovr_calc   = 1'b1;
      end
   end

   assign diff = total_ff - start_ff;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign dv_move    = dv_ff && out_free;
   assign rd_en      = cmd.stream && (remain_ff != '0) && (!dv_ff || dv_move);
   assign empty_load = cmd.push_empty && out_free;
   assign rd_addr_next = (rd_addr_ff == ADDR_W'(LOG_DEPTH - 1)) ?
                         '0 : (rd_addr_ff + ADDR_W'(1));

   always_comb begin
      total_in  = total_ff;
      wr_ptr_in = wr_ptr_ff;
      if (cmd.clr) begin
         total_in  = '0;
         wr_ptr_in = '0;
      end else if (cmd.wr) begin
         total_in  = total_ff + TOTAL_W'(1);
         wr_ptr_in = (wr_ptr_ff == ADDR_W'(LOG_DEPTH - 1)) ?
                     '0 : (wr_ptr_ff + ADDR_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         wr_ptr_ff    <= '0;
         remain_ff    <= '0;
         dv_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         total_ff  <= total_in;
         wr_ptr_ff <= wr_ptr_in;
         if (cmd.setup) begin
            remain_ff <= count_ff;
         end else if (rd_en) begin
            remain_ff <= remain_ff - CAP_W'(1);
         end
         if (rd_en) begin
            dv_ff <= 1'b1;
         end else if (dv_move) begin
            dv_ff <= 1'b0;
         end
         if (dv_move || empty_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         since_ff <= since_offset;
         cap_ff   <= (dest_capacity > MAX_CAP) ? MAX_CAP : dest_capacity;
      end
      if (cmd.zero) begin
         next_ff  <= total_ff;
         ovr_ff   <= 1'b0;
         count_ff <= '0;
      end
      if (cmd.start) begin
         start_ff <= start_calc;
         ovr_ff   <= ovr_calc;
      end
      if (cmd.clamp && (start_ff > total_ff)) begin
         start_ff <= total_ff;
      end
      if (cmd.count) begin
         if (diff > TOTAL_W'(room)) begin
            count_ff <= room;
            ovr_ff   <= 1'b1;
         end else begin
            count_ff <= diff[CAP_W-1:0];
         end
      end
      if (cmd.setup) begin
         next_ff    <= start_ff + TOTAL_W'(count_ff);
         rd_addr_ff <= start_ff[ADDR_W-1:0];
      end else if (rd_en) begin
         rd_addr_ff <= rd_addr_next;
      end
      if (rd_en) begin
         dv_last_ff <= (remain_ff == CAP_W'(1));
      end
      if (dv_move) begin
         out_byte_ff  <= ram_data;
         out_bv_ff    <= 1'b1;
         out_last_ff  <= dv_last_ff;
         out_next_ff  <= next_ff;
         out_ovr_ff   <= ovr_ff;
         out_count_ff <= count_ff;
      end else if (empty_load) begin
         out_byte_ff  <= '0;
         out_bv_ff    <= 1'b0;
         out_last_ff  <= 1'b1;
         out_next_ff  <= next_ff;
         out_ovr_ff   <= ovr_ff;
         out_count_ff <= '0;
      end
   end

   assign stat.zero_cap   = (cap_ff == '0);
   assign stat.count_zero = (count_ff == '0);
   assign stat.drained    = (remain_ff == '0) && !dv_ff;
   assign stat.out_free   = out_free;

   assign rsp_tvalid  = out_valid_ff;
   assign read_byte   = out_byte_ff;
   assign byte_valid  = out_bv_ff;
   assign last        = out_last_ff;
   assign next_offset = out_next_ff;
   assign overrun     = out_ovr_ff;
   assign bytes_read  = out_count_ff;

   a_no_issue_past_end: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (remain_ff != '0))
      else $error("read issued with no bytes remaining");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (dv_ff && dv_last_ff) |-> (remain_ff == '0))
      else $error("last byte in flight while bytes remain");

   a_empty_no_flight: assert property (@(posedge clock) disable iff (reset)
      cmd.push_empty |-> !dv_ff)
      else $error("empty result pushed while a byte is in flight");

   a_drain_then_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.stream && stat.drained) |=> !rd_en)
      else $error("read issued after stream drained");

endmodule

`default_nettype wire

/* sv/trace_log_ring_buffer.sv */
`default_nettype none

// Byte trace log kept in a 64 KiB ring with a 32-bit count of bytes ever written.
// req_tuser selects write, read or clear. A write or a clear leaves the block
// ready, so the next transfer can be taken in the following cycle. A read
// works out its start, byte count and overrun flag in four steps (start, clamp,
// count, setup), then streams its bytes at one per cycle through the ring RAM's
// registered read port, slowed only by rsp_tready; the next request is taken
// once the final byte has left the RAM output stage, while that byte may still
// wait in the output register. A read that returns no bytes gives one result
// with byte_valid low, from the start state for zero capacity, or after setup
// when the byte count is zero. A clear resets the count and write pointer only;
// the RAM needs no clearing pass since a read only reaches bytes written after it.
module trace_log_ring_buffer
   import tlrb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // data_byte[7:0], since_offset[39:8], dest_capacity[46:40], zero [47]
   input  wire logic [47:0] req_tdata,
   // command[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // read_byte[7:0], next_offset[39:8], overrun[40], bytes_read[47:41]
   output logic [47:0]      rsp_tdata,
   // byte_valid[0]
   output logic             rsp_tuser,
   output logic             rsp_tlast
);

   ctl_cmd_type        cmd;
   ctl_stat_type       stat;
   logic [BYTE_W-1:0]  read_byte;
   logic [TOTAL_W-1:0] next_offset;
   logic               overrun;
   logic [CAP_W-1:0]   bytes_read;

   tlrb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .command    (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   tlrb_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .data_byte     (req_tdata[7:0]),
      .since_offset  (req_tdata[39:8]),
      .dest_capacity (req_tdata[46:40]),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .read_byte     (read_byte),
      .byte_valid    (rsp_tuser),
      .last          (rsp_tlast),
      .next_offset   (next_offset),
      .overrun       (overrun),
      .bytes_read    (bytes_read)
   );

   assign rsp_tdata = {bytes_read, overrun, next_offset, read_byte};

endmodule

`default_nettype wire

/* dv/trace_log_checker.sv */
module trace_log_checker
   import tlrb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [47:0] req_tdata,
   input  wire logic [1:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [47:0] rsp_tdata,
   input  wire logic        rsp_tuser,
   input  wire logic        rsp_tlast,
   output int unsigned      mismatches,
   output int unsigned      pending
);

   typedef struct packed {
      logic [BYTE_W-1:0]  data;
      logic               valid;
      logic               last;
      logic [TOTAL_W-1:0] next;
      logic               overrun;
      logic [CAP_W-1:0]   count;
   } log_beat_type;

   logic [BYTE_W-1:0]  ring_copy [LOG_DEPTH];
   logic [TOTAL_W-1:0] bytes_logged;
   log_beat_type       beats_due [$];
   int unsigned        bad_beats = 0;

   task automatic push_beat(input logic [BYTE_W-1:0] data, input logic valid,
                            input logic last, input logic [TOTAL_W-1:0] next,
                            input logic overrun, input logic [CAP_W-1:0] count);
      log_beat_type beat;
      beat.data    = data;
      beat.valid   = valid;
      beat.last    = last;
      beat.next    = next;
      beat.overrun = overrun;
      beat.count   = count;
      beats_due.push_back(beat);
   endtask

   task automatic predict_read(input logic [TOTAL_W-1:0] since,
                               input logic [CAP_W-1:0] cap_req);
      logic [CAP_W-1:0]   cap;
      logic [TOTAL_W-1:0] room;
      logic [TOTAL_W-1:0] chunk;
      logic [TOTAL_W-1:0] first;
      logic [TOTAL_W-1:0] count;
      logic               skipped;
      cap = (cap_req > MAX_CAP) ? MAX_CAP : cap_req;
      if (cap == '0) begin
         push_beat('0, 1'b0, 1'b1, bytes_logged, 1'b0, '0);
         return;
      end
      room    = TOTAL_W'(cap) - 1;
      first   = since;
      skipped = 1'b0;
      if (since == '0) begin
         chunk = (HISTORY_CHUNK < room) ? TOTAL_W'(HISTORY_CHUNK) : room;
         first = (bytes_logged > chunk) ? bytes_logged - chunk : '0;
      end else if (64'(bytes_logged) > 64'(since) + 64'(LOG_DEPTH)) begin
         first   = bytes_logged - TOTAL_W'(LOG_DEPTH);
         skipped = 1'b1;
      end
      if (first > bytes_logged)
         first = bytes_logged;
      count = bytes_logged - first;
      if (count > room) begin
         count   = room;
         skipped = 1'b1;
      end
      if (count == '0)
         push_beat('0, 1'b0, 1'b1, first, skipped, '0);
      else
         for (int unsigned i = 0; i < count; i++)
            push_beat(ring_copy[ADDR_W'(first + i)], 1'b1, (i + 1 == count),
                      first + count, skipped, CAP_W'(count));
   endtask

   task automatic note_fault(input string what, input log_beat_type want,
                             input log_beat_type got);
      if (bad_beats < 10) begin
         $write("%s: expected byte %02h valid %0d last %0d next %08h overrun %0d count %0d,",
                what, want.data, want.valid, want.last, want.next, want.overrun,
                want.count);
         $display(" got byte %02h valid %0d last %0d next %08h overrun %0d count %0d",
                  got.data, got.valid, got.last, got.next, got.overrun, got.count);
      end
      bad_beats++;
   endtask

   always @(posedge clock) begin
      log_beat_type got;
      log_beat_type want;
      if (reset) begin
         bytes_logged = '0;
         beats_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.data    = rsp_tdata[7:0];
            got.next    = rsp_tdata[39:8];
            got.overrun = rsp_tdata[40];
            got.count   = rsp_tdata[47:41];
            got.valid   = rsp_tuser;
            got.last    = rsp_tlast;
            if (beats_due.size() == 0) begin
               want = '0;
               note_fault("unexpected transfer", want, got);
            end else begin
               want = beats_due.pop_front();
               if (got !== want)
                  note_fault("mismatch", want, got);
            end
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               CMD_WRITE: begin
                  ring_copy[ADDR_W'(bytes_logged)] = req_tdata[7:0];
                  bytes_logged = bytes_logged + 1;
               end
               CMD_READ:  predict_read(req_tdata[39:8], req_tdata[46:40]);
               CMD_CLEAR: bytes_logged = '0;
               default: ;
            endcase
         end
      end
      mismatches <= bad_beats;
      pending    <= beats_due.size();
   end

endmodule

/* dv/trace_log_ring_buffer_tb.sv */
module trace_log_ring_buffer_tb;
   import tlrb_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [47:0]        req_tdata;
   logic [1:0]         req_tuser;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [47:0]        rsp_tdata;
   logic               rsp_tuser;
   logic               rsp_tlast;
   int unsigned        mismatches;
   int unsigned        pending;
   logic [31:0]        cycle_count = '0;
   logic [TOTAL_W-1:0] sent_total;
   logic               steady;

   trace_log_ring_buffer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   trace_log_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // hold both sides busy for a long stretch in every window
   assign steady = (cycle_count % 2048) >= 1600;

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 28);
   end

   task automatic send_item(input logic [1:0] cmd, input logic [BYTE_W-1:0] data,
                            input logic [TOTAL_W-1:0] since, input logic [CAP_W-1:0] cap);
      while (!steady && $urandom_range(99) < 28) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {1'b0, cap, since, data};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (cmd == CMD_WRITE)
         sent_total = sent_total + 1;
      else if (cmd == CMD_CLEAR)
         sent_total = '0;
   endtask

   function automatic logic [TOTAL_W-1:0] pick_offset();
      logic [TOTAL_W-1:0] back;
      back = $urandom_range(0, 70);
      case ($urandom_range(0, 9))
         0, 1:       return '0;
         2, 3, 4, 5: return (sent_total > back) ? sent_total - back : TOTAL_W'(1);
         6:          return sent_total + $urandom_range(0, 3);
         7:          return sent_total - TOTAL_W'($urandom_range(65530, 65545));
         default:    return $urandom;
      endcase
   endfunction

   function automatic logic [CAP_W-1:0] pick_cap();
      if ($urandom_range(0, 9) < 8)
         return CAP_W'($urandom_range(1, 65));
      return CAP_W'($urandom_range(0, 127));
   endfunction

   initial begin : stimulus
      int unsigned pick;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= CMD_WRITE;
      sent_total = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_item(CMD_READ, 8'h00, 32'h0000_0000, 7'd0);
      send_item(CMD_READ, 8'hFF, 32'h0000_0000, 7'd65);
      send_item(CMD_WRITE, 8'h00, 32'hFFFF_FFFF, 7'd127);
      send_item(CMD_WRITE, 8'hFF, 32'h0000_0000, 7'd0);
      send_item(CMD_WRITE, 8'hA5, 32'h5555_5555, 7'd65);
      send_item(CMD_WRITE, 8'h5A, 32'hAAAA_AAAA, 7'd1);
      send_item(CMD_WRITE, 8'h01, 32'h0000_0001, 7'd66);
      send_item(CMD_READ, 8'h00, 32'h0000_0000, 7'd1);
      send_item(CMD_READ, 8'h00, 32'h0000_0000, 7'd3);
      send_item(CMD_READ, 8'h00, 32'h0000_0001, 7'd127);
      send_item(CMD_READ, 8'h00, 32'hFFFF_FFFF, 7'd65);
      send_item(CMD_READ, 8'h00, 32'h0000_0002, 7'd2);
      send_item(CMD_READ, 8'hFF, 32'hFFFF_FFFF, 7'd0);
      send_item(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 7'd127);
      send_item(CMD_READ, 8'h00, 32'h0000_0000, 7'd65);
      send_item(CMD_CLEAR, 8'hFF, 32'hFFFF_FFFF, 7'd127);
      send_item(CMD_READ, 8'h00, 32'h0000_0000, 7'd65);
      send_item(CMD_READ, 8'h00, 32'h0000_0003, 7'd65);
      send_item(CMD_WRITE, 8'h80, 32'h0000_0000, 7'd0);
      send_item(CMD_READ, 8'h00, 32'h0000_0000, 7'd65);

      repeat (166) begin
         pick = $urandom_range(99);
         if (pick < 62)
            send_item(CMD_WRITE, BYTE_W'($urandom), $urandom, CAP_W'($urandom));
         else if (pick < 93)
            send_item(CMD_READ, BYTE_W'($urandom), pick_offset(), pick_cap());
         else if (pick < 96)
            send_item(CMD_CLEAR, BYTE_W'($urandom), $urandom, CAP_W'($urandom));
         else
            send_item(CMD_UNUSED, BYTE_W'($urandom), $urandom, CAP_W'($urandom));
      end

      send_item(CMD_READ, 8'h00, 32'h0000_0001, 7'd65);
      send_item(CMD_READ, 8'h00, sent_total - TOTAL_W'(LOG_DEPTH), 7'd65);
      send_item(CMD_READ, 8'h00, sent_total - TOTAL_W'(LOG_DEPTH) - 1, 7'd40);
      send_item(CMD_READ, 8'h00, sent_total - 10, 7'd65);
      repeat (40) begin
         if ($urandom_range(0, 2) == 0)
            send_item(CMD_WRITE, BYTE_W'($urandom), $urandom, CAP_W'($urandom));
         else
            send_item(CMD_READ, BYTE_W'($urandom), pick_offset(), pick_cap());
      end
      req_tvalid <= 1'b0;

      repeat (2) @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #30_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

/* files.f */
sv/tlrb_pkg.sv
sv/tlrb_ram.sv
sv/tlrb_ctrl.sv
sv/tlrb_dpath.sv
sv/trace_log_ring_buffer.sv
dv/trace_log_checker.sv
dv/trace_log_ring_buffer_tb.sv
